FILE: rtl/lbp16_pkg.sv
// shared types, mode codes and helper functions for the lbp16 label mapper
package lbp16_pkg;

  localparam int CODE_W  = 16;
  localparam int MODE_W  = 2;
  localparam int ONES_W  = $clog2(CODE_W + 1);
  localparam int POS_W   = $clog2(CODE_W);
  localparam int ULBL_W  = 8;

  // uniform label of the all-ones code, one past the last run label
  localparam logic [ULBL_W-1:0] UNI_ALL_ONES = 8'd242;
  localparam logic [ULBL_W-1:0] UNI_RUN_BASE = 8'd2;

  typedef logic [CODE_W-1:0] code_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_ROT_INV = 2'd1,
    MODE_UNIFORM = 2'd2,
    MODE_UNI_RI  = 2'd3
  } mode_t;

  typedef struct packed {
    logic              is_zero;
    logic              is_uniform;
    logic              is_all_ones;
    logic [ONES_W-1:0] ones;
    logic [ULBL_W-1:0] run_label;
  } uni_info_t;

  function automatic code_t rot_right(input code_t v, input logic [POS_W-1:0] r);
    logic [2*CODE_W-1:0] dbl;
    dbl = {v, v} >> r;
    return dbl[CODE_W-1:0];
  endfunction

  function automatic logic [ONES_W-1:0] pop_count(input code_t v);
    logic [ONES_W-1:0] n;
    n = '0;
    for (int i = 0; i < CODE_W; i++) begin
      n = n + ONES_W'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: rtl/lbp16_code_if.sv
// stream channel carrying one pattern code per beat
interface lbp16_code_if import lbp16_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t pattern_code;

  modport source (output valid, output pattern_code, input ready);
  modport sink (input valid, input pattern_code, output ready);
endinterface

FILE: rtl/lbp16_label_if.sv
// stream channel carrying one mapped label per beat
interface lbp16_label_if import lbp16_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t label;

  modport source (output valid, output label, input ready);
  modport sink (input valid, input label, output ready);
endinterface

FILE: rtl/lbp16_min_rot.sv
// smallest circular rotation of a code through a four-level compare tree
module lbp16_min_rot import lbp16_pkg::*; (
  input  code_t code,
  output code_t min_code
);

  localparam int LVLS = $clog2(CODE_W);

  code_t lvl [0:LVLS][0:CODE_W-1];

  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int i = 0; i < CODE_W; i++) begin
        lvl[l][i] = '0;
      end
    end
    for (int i = 0; i < CODE_W; i++) begin
      lvl[0][i] = rot_right(code, POS_W'(i));
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < (CODE_W >> (l + 1)); i++) begin
        lvl[l+1][i] = (lvl[l][2*i+1] < lvl[l][2*i]) ? lvl[l][2*i+1] : lvl[l][2*i];
      end
    end
  end

  assign min_code = lvl[LVLS][0];

endmodule

FILE: rtl/lbp16_uniform.sv
// uniformity test, ones count and run label of a code
module lbp16_uniform import lbp16_pkg::*; (
  input  code_t     code,
  output uni_info_t info
);

  code_t             prev;
  code_t             run_start;
  logic [ONES_W-1:0] trans;
  logic [ONES_W-1:0] ones;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  offset;
  logic [POS_W-1:0]  len_m1;

  // prev[i] holds the bit below i, circularly
  assign prev  = {code[CODE_W-2:0], code[CODE_W-1]};
  assign trans = pop_count(code ^ prev);
  assign ones  = pop_count(code);

  // a uniform run has exactly one rising edge, so an or-encode is enough
  assign run_start = code & ~prev;

  always_comb begin
    start_pos = '0;
    for (int i = 0; i < CODE_W; i++) begin
      start_pos = start_pos | (run_start[i] ? POS_W'(i) : '0);
    end
  end

  assign offset = POS_W'(0) - start_pos;
  assign len_m1 = POS_W'(ones - ONES_W'(1));

  assign info.is_zero     = (code == '0);
  assign info.is_all_ones = (code == '1);
  assign info.is_uniform  = (trans <= ONES_W'(2));
  assign info.ones        = ones;
  assign info.run_label   = {len_m1, offset} + UNI_RUN_BASE;

endmodule

FILE: rtl/lbp16_label_mapper.sv
// top level: input register, mapping logic and result register
// Maps one 16-bit local binary pattern code to a label under the mode held in a
// 2-bit register (0 plain, 1 rotation invariant, 2 uniform, 3 uniform rotation
// invariant). One code is taken per clock unless the output stalls, and each
// gives exactly one label: a code register and a result register surround the
// mapping logic, whose longest path is the 16-way minimum-rotation compare tree.
// The mode register may only be written while no code is in flight.
module lbp16_label_mapper import lbp16_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  lbp16_code_if.sink          codes,
  lbp16_label_if.source       labels,
  input  logic                cfg_wr_en,
  input  logic [MODE_W-1:0]   cfg_wr_data
);

  mode_t     mapping_mode;
  logic      stage_valid;
  code_t     stage_code;
  logic      out_valid;
  code_t     label;
  code_t     label_next;
  code_t     min_code;
  uni_info_t uni;
  logic      out_free;

  lbp16_min_rot u_min_rot (
    .code     (stage_code),
    .min_code (min_code)
  );

  lbp16_uniform u_uniform (
    .code (stage_code),
    .info (uni)
  );

  assign out_free     = !out_valid || labels.ready;
  assign codes.ready  = !stage_valid || out_free;
  assign labels.valid = out_valid;
  assign labels.label = label;

  always_comb begin
    case (mapping_mode)
      MODE_PLAIN: begin
        label_next = stage_code;
      end
      MODE_ROT_INV: begin
        label_next = min_code;
      end
      MODE_UNIFORM: begin
        if (uni.is_zero) begin
          label_next = CODE_W'(1);
        end else if (!uni.is_uniform) begin
          label_next = '0;
        end else if (uni.is_all_ones) begin
          label_next = CODE_W'(UNI_ALL_ONES);
        end else begin
          label_next = CODE_W'(uni.run_label);
        end
      end
      MODE_UNI_RI: begin
        if (uni.is_zero) begin
          label_next = CODE_W'(1);
        end else if (!uni.is_uniform) begin
          label_next = '0;
        end else begin
          label_next = CODE_W'(uni.ones) + CODE_W'(1);
        end
      end
      default: begin
        label_next = stage_code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_mode <= MODE_PLAIN;
      stage_valid  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mapping_mode <= mode_t'(cfg_wr_data);
      end
      if (codes.ready) begin
        stage_valid <= codes.valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (codes.valid && codes.ready) begin
      stage_code <= codes.pattern_code;
    end
    if (out_free && stage_valid) begin
      label <= label_next;
    end
  end

endmodule

FILE: rtl/lbp16_chk.sv
// port-level checker for the label mapper and its bind
module lbp16_chk import lbp16_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input code_t             label,
  input logic              cfg_wr_en,
  input logic [MODE_W-1:0] cfg_wr_data
);

  mode_t      mode_seen;
  logic [1:0] in_flight;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_seen <= MODE_PLAIN;
      in_flight <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_seen <= mode_t'(cfg_wr_data);
      end
      in_flight <= in_flight + 2'(in_beat) - 2'(out_beat);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(label))
    else $error("label changed while stalled");

  // two registers, so never more than two codes awaiting a label
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight != 2'd3 && (!out_valid || in_flight != 2'd0))
    else $error("label count does not match accepted codes");

  a_uni_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_seen == MODE_UNIFORM |-> label <= CODE_W'(UNI_ALL_ONES))
    else $error("uniform label out of range");

  a_uri_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_seen == MODE_UNI_RI |-> label <= CODE_W'(CODE_W + 1))
    else $error("uniform rotation invariant label out of range");

endmodule

bind lbp16_label_mapper lbp16_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (codes.valid),
  .in_ready    (codes.ready),
  .out_valid   (labels.valid),
  .out_ready   (labels.ready),
  .label       (labels.label),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);
